// ===== hdl/pli_pkg.sv =====
// ============================================================================
// pli_pkg: shared types and constants for the piecewise-linear interpolator
// Field widths, function codes, value limits and the handshake status of the
// bit-serial arithmetic units.
// ============================================================================
`default_nettype none

package pli_pkg;

    // Field widths
    localparam int ENERGY_W = 32;               // unsigned Q16.16
    localparam int VALUE_W  = 18;               // signed Q2.16
    localparam int INDEX_W  = 5;
    localparam int CFG_W    = 6;

    // Arithmetic widths
    localparam int DV_W   = VALUE_W + 1;        // value difference, signed
    localparam int MAG_W  = VALUE_W;            // |value difference|
    localparam int PROD_W = MAG_W + ENERGY_W;   // |dv| * |dq|
    localparam int NUM_W  = PROD_W + 1;         // product plus half divisor
    localparam int QUOT_W = VALUE_W + 1;        // quotient bits kept
    localparam int SUM_W  = VALUE_W + 3;        // final sum before clipping

    localparam int DEFAULT_DEPTH = 32;

    // Function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 6'd2;
    localparam logic [CFG_W-1:0] ENTRIES_MIN   = 6'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 18'sh1FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 18'sh20000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

`default_nettype wire

// ===== hdl/pli_ram.sv =====
// ============================================================================
// pli_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module pli_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/pli_mul.sv =====
// ============================================================================
// pli_mul: radix-4 serial multiplier
// Unsigned |dv| * |dq|, two multiplier bits per cycle, shift-right accumulate.
// ============================================================================
`default_nettype none

module pli_mul (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pli_pkg::MAG_W-1:0]      i_multiplicand,
    input  wire logic [pli_pkg::ENERGY_W-1:0]   i_multiplier,
    output pli_pkg::t_unit_status               o_status,
    output logic      [pli_pkg::PROD_W-1:0]     o_product
);

    localparam int STEPS = pli_pkg::ENERGY_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int ACC_W = pli_pkg::MAG_W + 2;

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [ACC_W-1:0]                r_m1;
    logic [ACC_W-1:0]                r_m3;
    logic [ACC_W-1:0]                r_acc;
    logic [pli_pkg::ENERGY_W-1:0]    r_lo;

    logic [ACC_W-1:0] n_m1;
    logic [ACC_W-1:0] n_addend;
    logic [ACC_W-1:0] n_sum;

    assign n_m1 = ACC_W'(i_multiplicand);

    always_comb begin
        unique case (r_lo[1:0])
            2'd0:    n_addend = '0;
            2'd1:    n_addend = r_m1;
            2'd2:    n_addend = {r_m1[ACC_W-2:0], 1'b0};
            default: n_addend = r_m3;
        endcase
    end

    // acc stays below the multiplicand after each shift, so no carry is lost
    assign n_sum = r_acc + n_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS - 1);
                r_m1   <= n_m1;
                r_m3   <= n_m1 + {n_m1[ACC_W-2:0], 1'b0};
                r_acc  <= '0;
                r_lo   <= i_multiplier;
            end else if (r_busy) begin
                r_acc <= {2'b00, n_sum[ACC_W-1:2]};
                r_lo  <= {n_sum[1:0], r_lo[pli_pkg::ENERGY_W-1:2]};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = {r_acc[pli_pkg::MAG_W-1:0], r_lo};

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("multiplier done without a run");

endmodule

`default_nettype wire

// ===== hdl/pli_div.sv =====
// ============================================================================
// pli_div: serial rounding divider
// Adds half the divisor, checks quotient overflow, then one restoring
// step per cycle for the kept quotient bits.
// ============================================================================
`default_nettype none

module pli_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pli_pkg::PROD_W-1:0]     i_product,
    input  wire logic [pli_pkg::ENERGY_W-1:0]   i_divisor,
    output pli_pkg::t_unit_status               o_status,
    output logic      [pli_pkg::QUOT_W-1:0]     o_quotient,
    output logic                                o_overflow
);

    localparam int EW    = pli_pkg::ENERGY_W;
    localparam int QW    = pli_pkg::QUOT_W;
    localparam int NW    = pli_pkg::NUM_W;
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_CHECK,
        S_LOOP
    } t_state;

    t_state           r_state;
    logic             r_done;
    logic             r_overflow;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_num;
    logic [EW-1:0]    r_den;
    logic [EW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;

    logic [EW:0]   n_trial;
    logic [EW:0]   n_diff;
    logic          n_ge;
    logic [EW-1:0] n_top;

    assign n_top   = r_num[NW-1:QW];
    assign n_trial = {r_rem, r_quo[QW-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_ge    = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_num   <= {1'b0, i_product};
                        r_den   <= i_divisor;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    // round to nearest, ties up in magnitude
                    r_num   <= r_num + NW'(r_den[EW-1:1]);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_rem <= n_top;
                    r_quo <= r_num[QW-1:0];
                    r_cnt <= CNT_W'(QW - 1);
                    if (n_top >= r_den) begin
                        r_overflow <= 1'b1;
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_overflow <= 1'b0;
                        r_state    <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    r_rem <= n_ge ? n_diff[EW-1:0] : n_trial[EW-1:0];
                    r_quo <= {r_quo[QW-2:0], n_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status.busy = (r_state != S_IDLE);
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;
    assign o_overflow    = r_overflow;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// ===== hdl/piecewise_linear_interpolator.sv =====
// ============================================================================
// piecewise_linear_interpolator: table lookup with linear interpolation
// Loads (energy, value) points into a table RAM; a query scans for its
// segment and interpolates or extrapolates with serial multiply and divide.
// ============================================================================
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+-------------------------------------
//  in      | i_in_valid | o_in_ready  | i_func, i_entry_index, i_entry_energy,
//          |            |             | i_entry_value, i_query_energy
//  out     | o_out_valid| i_out_ready | o_interpolated_value, o_saturated
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_data (entries_in_use)
//
//  A load is written into the table as it is taken. A query scans for its
//  segment with one RAM read per cycle, then runs the radix-4 multiplier
//  and the divider, which yields 19 quotient bits.
//  Reset clears control and sets entries_in_use to 2; the table RAM is not
//  cleared and every entry must be loaded before a query reads it.
//  A new transaction is taken while a result waits in the output register;
//  a finished query holds until that register is free.
//
`default_nettype none

module piecewise_linear_interpolator #(
    parameter int TABLE_DEPTH = pli_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_func,
    input  wire logic        [pli_pkg::INDEX_W-1:0]    i_entry_index,
    input  wire logic        [pli_pkg::ENERGY_W-1:0]   i_entry_energy,
    input  wire logic signed [pli_pkg::VALUE_W-1:0]    i_entry_value,
    input  wire logic        [pli_pkg::ENERGY_W-1:0]   i_query_energy,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed      [pli_pkg::VALUE_W-1:0]    o_interpolated_value,
    output logic                                       o_saturated,
    // configuration
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic        [pli_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int EW    = pli_pkg::ENERGY_W;
    localparam int VW    = pli_pkg::VALUE_W;
    localparam int DVW   = pli_pkg::DV_W;
    localparam int SW    = pli_pkg::SUM_W;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_W = EW + VW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [pli_pkg::CFG_W-1:0]   r_entries;
    logic [EW-1:0]               r_query;
    logic                        r_hi;
    logic [AW-1:0]               r_k;
    logic [EW-1:0]               r_prev_e;
    logic signed [VW-1:0]        r_prev_v;
    logic signed [VW-1:0]        r_v0;
    logic [DVW-1:0]              r_dv;
    logic [EW:0]                 r_dq;
    logic [EW:0]                 r_de;
    logic                        r_flat;
    logic [EW-1:0]               r_mag_de;
    logic                        r_neg;
    logic signed [VW-1:0]        r_res;
    logic                        r_sat;
    logic                        r_out_valid;
    logic signed [VW-1:0]        r_out_value;
    logic                        r_out_sat;

    logic                        w_in_fire;
    logic                        w_out_fire;
    logic                        w_out_load;
    logic                        w_cfg_fire;
    logic [CNT_W-1:0]            w_count;
    logic [AW-1:0]               w_last;
    logic [AW-1:0]               w_k_next;
    logic                        w_we;
    logic                        w_re;
    logic [AW-1:0]               w_raddr;
    logic [RAM_W-1:0]            w_rdata;
    logic [EW-1:0]               w_rd_e;
    logic signed [VW-1:0]        w_rd_v;
    logic                        w_select;
    logic [DVW-1:0]              w_abs_dv;
    logic [EW:0]                 w_abs_dq;
    logic [EW:0]                 w_abs_de;
    logic                        w_mul_start;
    logic                        w_div_start;
    pli_pkg::t_unit_status       w_mul_status;
    pli_pkg::t_unit_status       w_div_status;
    logic [pli_pkg::PROD_W-1:0]  w_product;
    logic [pli_pkg::QUOT_W-1:0]  w_quotient;
    logic                        w_overflow;
    logic signed [SW-1:0]        w_qext;
    logic signed [SW-1:0]        w_sq;
    logic signed [SW-1:0]        w_sum;
    logic signed [VW-1:0]        w_res;
    logic                        w_sat;

    assign w_in_fire  = i_in_valid & o_in_ready;
    assign w_out_fire = r_out_valid & i_out_ready;
    assign w_cfg_fire = i_cfg_valid & o_cfg_ready;

    // finished result moves into the output register when it is free
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // point count clamped to 2..TABLE_DEPTH
    always_comb begin
        priority if (r_entries < pli_pkg::ENTRIES_MIN) begin
            w_count = CNT_W'(pli_pkg::ENTRIES_MIN);
        end else if (32'(r_entries) > 32'(TABLE_DEPTH)) begin
            w_count = CNT_W'(TABLE_DEPTH);
        end else begin
            w_count = CNT_W'(r_entries);
        end
    end

    assign w_last   = AW'(w_count - CNT_W'(1));
    assign w_k_next = r_k + AW'(1);

    assign w_we = w_in_fire && (i_func == pli_pkg::FUNC_LOAD)
                  && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    // Read order: last point first, then points 0, 1, ... one per cycle
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                w_re    = w_in_fire && (i_func == pli_pkg::FUNC_QUERY);
                w_raddr = w_last;
            end
            S_LAST: begin
                w_re    = 1'b1;
                w_raddr = '0;
            end
            S_SCAN: begin
                w_re    = 1'b1;
                w_raddr = w_k_next;
            end
            default: begin
                w_re    = 1'b0;
                w_raddr = w_last;
            end
        endcase
    end

    pli_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata ({i_entry_energy, i_entry_value}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_e = w_rdata[RAM_W-1:VW];
    assign w_rd_v = w_rdata[VW-1:0];

    // prev holds point k-1, read data holds point k (k >= 1).
    // Below the first point wins over above the last.
    assign w_select = ((r_k == AW'(1)) && (r_query < r_prev_e))
                   || (!r_hi && (r_prev_e <= r_query) && (r_query <= w_rd_e))
                   || (r_k == w_last);

    assign w_abs_dv = r_dv[DVW-1] ? -r_dv : r_dv;
    assign w_abs_dq = r_dq[EW]    ? -r_dq : r_dq;
    assign w_abs_de = r_de[EW]    ? -r_de : r_de;

    assign w_mul_start = (r_state == S_PREP) && !r_flat;
    assign w_div_start = (r_state == S_MUL) && w_mul_status.done;

    pli_mul u_mul (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_mul_start),
        .i_multiplicand (w_abs_dv[pli_pkg::MAG_W-1:0]),
        .i_multiplier   (w_abs_dq[EW-1:0]),
        .o_status       (w_mul_status),
        .o_product      (w_product)
    );

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_product  (w_product),
        .i_divisor  (r_mag_de),
        .o_status   (w_div_status),
        .o_quotient (w_quotient),
        .o_overflow (w_overflow)
    );

    // apply sign, add base value, clip
    assign w_qext = SW'($signed({1'b0, w_quotient}));
    assign w_sq   = r_neg ? -w_qext : w_qext;
    assign w_sum  = SW'(r_v0) + w_sq;

    always_comb begin
        priority if (w_overflow) begin
            w_res = r_neg ? pli_pkg::VALUE_MIN : pli_pkg::VALUE_MAX;
            w_sat = 1'b1;
        end else if (w_sum > SW'(pli_pkg::VALUE_MAX)) begin
            w_res = pli_pkg::VALUE_MAX;
            w_sat = 1'b1;
        end else if (w_sum < SW'(pli_pkg::VALUE_MIN)) begin
            w_res = pli_pkg::VALUE_MIN;
            w_sat = 1'b1;
        end else begin
            w_res = w_sum[VW-1:0];
            w_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_entries   <= pli_pkg::ENTRIES_RESET;
        end else begin
            if (w_cfg_fire) begin
                r_entries <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire && (i_func == pli_pkg::FUNC_QUERY)) begin
                        r_query <= i_query_energy;
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_hi    <= r_query > w_rd_e;
                    r_k     <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_prev_e <= w_rd_e;
                    r_prev_v <= w_rd_v;
                    r_k      <= w_k_next;
                    if ((r_k != '0) && w_select) begin
                        r_dv    <= {w_rd_v[VW-1], w_rd_v} - {r_prev_v[VW-1], r_prev_v};
                        r_dq    <= {1'b0, r_query} - {1'b0, r_prev_e};
                        r_de    <= {1'b0, w_rd_e} - {1'b0, r_prev_e};
                        r_flat  <= (w_rd_e == r_prev_e);
                        r_v0    <= r_prev_v;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_mag_de <= w_abs_de[EW-1:0];
                    r_neg    <= r_dv[DVW-1] ^ r_dq[EW] ^ r_de[EW];
                    if (r_flat) begin
                        // zero-width segment: lower value, never clipped
                        r_res   <= r_v0;
                        r_sat   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_status.done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_status.done) begin
                        r_res   <= w_res;
                        r_sat   <= w_sat;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_value <= r_res;
                        r_out_sat   <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_out_valid          = r_out_valid;
    assign o_interpolated_value = r_out_value;
    assign o_saturated          = r_out_sat;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= w_last))
        else $error("segment scan past last point");

    a_mul_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (w_mul_status.busy || w_mul_status.done))
        else $error("waiting on an idle multiplier");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_interpolated_value == pli_pkg::VALUE_MAX
             || o_interpolated_value == pli_pkg::VALUE_MIN))
        else $error("saturated result not at a limit");

endmodule

`default_nettype wire
